// ----- rtl/rc4_stream_cipher_unit_macros.svh -----
// ----------------------------------------------------------------------------
// rc4 stream cipher unit assertion macros
// shared assertion wrappers, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef RC4_STREAM_CIPHER_UNIT_MACROS_SVH
`define RC4_STREAM_CIPHER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every edge outside reset
`define RC4_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// condition must never be seen outside reset
`define RC4_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define RC4_ASSERT(lbl, clk, rstn, prop, msg)
`define RC4_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif

`endif

// ----- rtl/rc4_pkg.sv -----
// ----------------------------------------------------------------------------
// rc4 package
// shared widths, command codes, sequencer states and s-box port struct
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rc4_pkg;

  localparam int BYTE_W       = 8;
  localparam int SBOX_DEPTH   = 256;
  localparam int LEN_W        = 9;
  localparam int CMD_W        = 2;
  localparam int KEY_DEPTH_DEF = 256;
  // key_index, key_byte, key_length, data_byte packed and padded to bytes
  localparam int IN_TDATA_W   = 40;

  typedef enum logic [CMD_W-1:0] {
    CMD_KEY   = 2'd0,
    CMD_SCHED = 2'd1,
    CMD_DATA  = 2'd2
  } cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCH_RD,
    ST_SCH_J,
    ST_SCH_SI,
    ST_SCH_SJ,
    ST_CR_J,
    ST_CR_SI,
    ST_CR_SJ,
    ST_CR_KS,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic              we;
    logic              clr;
    logic [BYTE_W-1:0] waddr;
    logic [BYTE_W-1:0] wdata;
    logic [BYTE_W-1:0] raddr;
  } sbox_req_t;

endpackage

// ----- rtl/rc4_sbox_ram.sv -----
// ----------------------------------------------------------------------------
// rc4 s-box memory
// 256 x 8 memory, one write and one registered read per cycle, per-entry
// valid bits so unwritten entries read as their own address
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rc4_sbox_ram import rc4_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sbox_req_t         req_i,
  output logic [BYTE_W-1:0] rdata_o
);

  logic [BYTE_W-1:0]     mem_q [SBOX_DEPTH];
  logic [SBOX_DEPTH-1:0] vld_q;
  logic [BYTE_W-1:0]     rd_q;
  logic                  rd_vld_q;
  logic                  fwd_q;
  logic [BYTE_W-1:0]     fwd_data_q;
  logic [BYTE_W-1:0]     raddr_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    rd_q       <= mem_q[req_i.raddr];
    fwd_data_q <= req_i.wdata;
    raddr_q    <= req_i.raddr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
      fwd_q    <= 1'b0;
    end else begin
      if (req_i.clr) begin
        vld_q <= '0;
      end else if (req_i.we) begin
        vld_q[req_i.waddr] <= 1'b1;
      end
      rd_vld_q <= vld_q[req_i.raddr] & ~req_i.clr;
      // write-first: a read of the address being written sees the new byte
      fwd_q    <= req_i.we && (req_i.waddr == req_i.raddr);
    end
  end

  assign rdata_o = fwd_q ? fwd_data_q : (rd_vld_q ? rd_q : raddr_q);

endmodule

// ----- rtl/rc4_stream_cipher_unit.sv -----
// ----------------------------------------------------------------------------
// rc4 stream cipher unit
// arcfour engine: key store, key schedule and byte encrypt/decrypt
// ----------------------------------------------------------------------------
// One command word at a time, one result word per command. A key byte write
// or an unused command goes straight to the result; a data byte and each
// swap step of the key schedule are paced by the single read port of the
// s-box memory, which every dependent read of a step goes through. The result
// sits in an output register, so the next command word is taken while the
// previous result waits; the engine only stalls when a new result is ready
// and the old one has not been taken.
// After reset the s-box is the identity permutation.
`timescale 1ns / 1ps
`include "rc4_stream_cipher_unit_macros.svh"

module rc4_stream_cipher_unit import rc4_pkg::*; #(
  parameter int KEY_DEPTH = KEY_DEPTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // key_index[7:0], key_byte[15:8], key_length[24:16], data_byte[32:25], zero
  input  logic [IN_TDATA_W-1:0] s_axis_tdata_i,
  input  logic                  s_axis_tlast_i,   // last_in_block
  input  logic [CMD_W-1:0]      s_axis_tuser_i,   // command
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [BYTE_W-1:0]     m_axis_tdata_o,   // out_byte
  output logic                  m_axis_tlast_o,   // end_of_block
  output logic                  m_axis_tuser_o    // keyed
);

  localparam int KEY_AW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;

  state_e state_q, state_d;

  logic [BYTE_W-1:0] i_q, i_d;
  logic [BYTE_W-1:0] j_q, j_d;
  logic [BYTE_W-1:0] si_q, si_d;
  logic [BYTE_W-1:0] sj_q, sj_d;
  logic [BYTE_W-1:0] data_q, data_d;
  logic [BYTE_W-1:0] ob_q, ob_d;
  logic              eob_q, eob_d;
  logic              keyed_q, keyed_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic [KEY_AW-1:0] kpos_q, kpos_d;

  logic              out_vld_q;
  logic [BYTE_W-1:0] out_data_q;
  logic              out_last_q;
  logic              out_user_q;

  logic [BYTE_W-1:0] key_mem [KEY_DEPTH];
  logic [BYTE_W-1:0] key_rd_q;

  sbox_req_t         sreq;
  logic [BYTE_W-1:0] srd;

  logic              in_acc;
  logic              fin_load;
  cmd_e              cmd;
  logic [BYTE_W-1:0] in_kidx;
  logic [BYTE_W-1:0] in_kbyte;
  logic [LEN_W-1:0]  in_klen;
  logic [BYTE_W-1:0] in_data;
  logic [LEN_W-1:0]  kpos_inc;
  logic              key_we;

  assign cmd      = cmd_e'(s_axis_tuser_i);
  assign in_kidx  = s_axis_tdata_i[7:0];
  assign in_kbyte = s_axis_tdata_i[15:8];
  assign in_klen  = s_axis_tdata_i[24:16];
  assign in_data  = s_axis_tdata_i[32:25];

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign fin_load        = (state_q == ST_FIN) && (!out_vld_q || m_axis_tready_i);
  assign kpos_inc        = LEN_W'(kpos_q) + LEN_W'(1);
  assign key_we          = in_acc && (cmd == CMD_KEY) &&
                           ({1'b0, in_kidx} < LEN_W'(KEY_DEPTH));

  rc4_sbox_ram u_sbox (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (sreq),
    .rdata_o (srd)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (cmd)
            CMD_SCHED: state_d = ST_SCH_RD;
            CMD_DATA:  state_d = ST_CR_J;
            default:   state_d = ST_FIN;
          endcase
        end
      end
      ST_SCH_RD: state_d = ST_SCH_J;
      ST_SCH_J:  state_d = ST_SCH_SI;
      ST_SCH_SI: state_d = ST_SCH_SJ;
      ST_SCH_SJ: state_d = (i_q == '1) ? ST_FIN : ST_SCH_J;
      ST_CR_J:   state_d = ST_CR_SI;
      ST_CR_SI:  state_d = ST_CR_SJ;
      ST_CR_SJ:  state_d = ST_CR_KS;
      ST_CR_KS:  state_d = ST_FIN;
      ST_FIN:    state_d = fin_load ? ST_IDLE : ST_FIN;
      default:   state_d = ST_IDLE;
    endcase
  end

  // datapath and memory control per state
  always_comb begin
    i_d     = i_q;
    j_d     = j_q;
    si_d    = si_q;
    sj_d    = sj_q;
    data_d  = data_q;
    ob_d    = ob_q;
    eob_d   = eob_q;
    keyed_d = keyed_q;
    len_d   = len_q;
    kpos_d  = kpos_q;
    sreq    = '{we: 1'b0, clr: 1'b0, waddr: i_q, wdata: sj_q, raddr: i_q};
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          ob_d  = '0;
          eob_d = 1'b0;
          case (cmd)
            CMD_SCHED: begin
              sreq.clr = 1'b1;
              i_d      = '0;
              j_d      = '0;
              kpos_d   = '0;
              if (in_klen == '0) begin
                len_d = LEN_W'(1);
              end else if (in_klen > LEN_W'(KEY_DEPTH)) begin
                len_d = LEN_W'(KEY_DEPTH);
              end else begin
                len_d = in_klen;
              end
            end
            CMD_DATA: begin
              i_d        = i_q + 8'd1;
              sreq.raddr = i_q + 8'd1;
              data_d     = in_data;
              eob_d      = s_axis_tlast_i;
            end
            default: ;
          endcase
        end
      end
      ST_SCH_RD: begin
        sreq.raddr = i_q;
      end
      ST_SCH_J: begin
        // j += s[k] + key[k mod len]
        si_d       = srd;
        j_d        = j_q + srd + key_rd_q;
        sreq.raddr = j_d;
      end
      ST_SCH_SI, ST_CR_SI: begin
        sj_d       = srd;
        sreq.we    = 1'b1;
        sreq.waddr = i_q;
        sreq.wdata = srd;
      end
      ST_SCH_SJ: begin
        sreq.we    = 1'b1;
        sreq.waddr = j_q;
        sreq.wdata = si_q;
        // fetch s[k+1] alongside the second half of the swap
        sreq.raddr = i_q + 8'd1;
        i_d        = i_q + 8'd1;
        kpos_d     = (kpos_inc >= len_q) ? '0 : kpos_inc[KEY_AW-1:0];
        if (i_q == '1) begin
          j_d     = '0;
          keyed_d = 1'b1;
        end
      end
      ST_CR_J: begin
        si_d       = srd;
        j_d        = j_q + srd;
        sreq.raddr = j_d;
      end
      ST_CR_SJ: begin
        sreq.we    = 1'b1;
        sreq.waddr = j_q;
        sreq.wdata = si_q;
        sreq.raddr = si_q + sj_q;
      end
      ST_CR_KS: begin
        ob_d = data_q ^ srd;
      end
      ST_FIN: ;
      default: ;
    endcase
  end

  // key store
  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[in_kidx[KEY_AW-1:0]] <= in_kbyte;
    end
    key_rd_q <= key_mem[kpos_d];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      i_q       <= '0;
      j_q       <= '0;
      keyed_q   <= 1'b0;
      len_q     <= LEN_W'(1);
      kpos_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      keyed_q <= keyed_d;
      len_q   <= len_d;
      kpos_q  <= kpos_d;
      if (fin_load) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    si_q   <= si_d;
    sj_q   <= sj_d;
    data_q <= data_d;
    ob_q   <= ob_d;
    eob_q  <= eob_d;
    if (fin_load) begin
      out_data_q <= ob_q;
      out_last_q <= eob_q;
      out_user_q <= keyed_q;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tuser_o  = out_user_q;

  `RC4_ASSERT_NEVER(a_keyed_sticky, clk_i, rst_ni, $fell(keyed_q),
                    "keyed flag dropped")
  `RC4_ASSERT(a_sched_start, clk_i, rst_ni,
              (state_q == ST_SCH_RD) |-> (i_q == '0 && j_q == '0 && kpos_q == '0),
              "schedule started with nonzero indices")
  `RC4_ASSERT(a_sched_end, clk_i, rst_ni,
              (state_q == ST_SCH_SJ && i_q == '1) |=>
                (state_q == ST_FIN && i_q == '0 && j_q == '0 && keyed_q),
              "schedule did not finish with cleared indices")
  `RC4_ASSERT(a_fin_hold, clk_i, rst_ni,
              (state_q == ST_FIN && out_vld_q && !m_axis_tready_i) |=>
                (state_q == ST_FIN),
              "result overwrote a word not yet taken")

endmodule

// ----- test/tb_rc4_stream_cipher_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc4 stream cipher unit testbench
// drives command words (key byte writes, key schedules, data bytes and the
// unused code) through the slave stream, keeps its own rc4 state to predict
// every result word, and checks the master stream against it in order while
// both sides idle at random, but for the back-to-back run
// ----------------------------------------------------------------------------

module tb_rc4_stream_cipher_unit import rc4_pkg::*;;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int FIRST_WORDS  = 300;
  localparam int TOTAL_WORDS  = 800;
  localparam int IDLE_PERCENT = 36;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              end_of_block;
    logic              keyed;
  } cipher_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [IN_TDATA_W-1:0] s_axis_tdata_i = '0;
  logic                  s_axis_tlast_i = 1'b0;
  logic [CMD_W-1:0]      s_axis_tuser_i = '0;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [BYTE_W-1:0]     m_axis_tdata_o;
  logic                  m_axis_tlast_o;
  logic                  m_axis_tuser_o;

  // shadow cipher state
  logic [BYTE_W-1:0] sbox_shadow [SBOX_DEPTH];
  logic [BYTE_W-1:0] key_shadow [KEY_DEPTH_DEF];
  logic              key_written [KEY_DEPTH_DEF];
  logic [BYTE_W-1:0] ptr_i, ptr_j;
  logic              keyed_shadow;

  cipher_result_t expected_results [$];
  int             words_sent;
  int             error_count = 0;
  int             cycle_count = 0;
  logic           no_idle;

  rc4_stream_cipher_unit u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_rc4_stream_cipher_unit: done, errors");
      $finish;
    end
  end

  // next state of the shadow cipher for one accepted word, and its result
  function automatic cipher_result_t rc4_apply_word(
    logic [CMD_W-1:0] cmd, logic [7:0] kidx, logic [7:0] kbyte,
    logic [8:0] klen, logic [7:0] dbyte, logic blk_last);
    cipher_result_t res;
    int unsigned    len, kpos, k;
    logic [7:0]     j, si, sj;
    res = '0;
    case (cmd)
      CMD_KEY: begin
        key_shadow[kidx]  = kbyte;
        key_written[kidx] = 1'b1;
      end
      CMD_SCHED: begin
        len = klen;
        if (len == 0) len = 1;
        if (len > KEY_DEPTH_DEF) len = KEY_DEPTH_DEF;
        for (k = 0; k < SBOX_DEPTH; k++) sbox_shadow[k] = 8'(k);
        j = '0;
        kpos = 0;
        for (k = 0; k < SBOX_DEPTH; k++) begin
          j = j + sbox_shadow[k] + key_shadow[kpos];
          si = sbox_shadow[k];
          sbox_shadow[k] = sbox_shadow[j];
          sbox_shadow[j] = si;
          kpos++;
          if (kpos >= len) kpos = 0;
        end
        ptr_i = '0;
        ptr_j = '0;
        keyed_shadow = 1'b1;
      end
      CMD_DATA: begin
        ptr_i = ptr_i + 8'd1;
        si = sbox_shadow[ptr_i];
        ptr_j = ptr_j + si;
        sj = sbox_shadow[ptr_j];
        sbox_shadow[ptr_i] = sj;
        sbox_shadow[ptr_j] = si;
        res.out_byte = dbyte ^ sbox_shadow[8'(si + sj)];
        res.end_of_block = blk_last;
      end
      default: ;
    endcase
    res.keyed = keyed_shadow;
    return res;
  endfunction

  // length of the key store run written from entry zero
  function automatic int key_prefix();
    int n;
    n = 0;
    while (n < KEY_DEPTH_DEF && key_written[n]) n++;
    return n;
  endfunction

  task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [7:0] kidx,
                           input logic [7:0] kbyte, input logic [8:0] klen,
                           input logic [7:0] dbyte, input logic blk_last);
    while (!no_idle && $urandom_range(0, 99) < IDLE_PERCENT) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {7'd0, dbyte, klen, kbyte, kidx};
    s_axis_tlast_i  <= blk_last;
    s_axis_tuser_i  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready_o);
    expected_results.push_back(rc4_apply_word(cmd, kidx, kbyte, klen, dbyte, blk_last));
    words_sent++;
  endtask

  // unused fields of each command carry random noise
  task automatic write_key(input logic [7:0] kidx, input logic [7:0] kbyte);
    send_word(CMD_KEY, kidx, kbyte, 9'($urandom_range(0, 511)), 8'($urandom),
              1'($urandom));
  endtask

  task automatic schedule_key(input logic [8:0] klen);
    send_word(CMD_SCHED, 8'($urandom), 8'($urandom), klen, 8'($urandom), 1'($urandom));
  endtask

  task automatic crypt_byte(input logic [7:0] dbyte, input logic blk_last);
    send_word(CMD_DATA, 8'($urandom), 8'($urandom), 9'($urandom_range(0, 511)), dbyte,
              blk_last);
  endtask

  task automatic send_unused();
    send_word(CMD_UNUSED, 8'($urandom), 8'($urandom), 9'($urandom_range(0, 511)),
              8'($urandom), 1'($urandom));
  endtask

  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (expected_results.size() != 0);
  endtask

  // write entries 0..n-1 in shuffled order with random bytes, plus stray random writes
  task automatic load_key(input int n);
    int unsigned order [KEY_DEPTH_DEF];
    int unsigned k, r, t;
    for (k = 0; k < n; k++) order[k] = k;
    for (k = n - 1; k > 0; k--) begin
      r = $urandom_range(0, k);
      t = order[k];
      order[k] = order[r];
      order[r] = t;
    end
    for (k = 0; k < n; k++) begin
      write_key(8'(order[k]), 8'($urandom));
      if ($urandom_range(0, 7) == 0) write_key(8'($urandom), 8'($urandom));
    end
  endtask

  task automatic test_before_keying();
    crypt_byte(8'h00, 1'b0);
    crypt_byte(8'hff, 1'b1);
    send_word(CMD_UNUSED, 8'hff, 8'hff, 9'h1ff, 8'hff, 1'b1);
    crypt_byte(8'h5a, 1'b0);
    write_key(8'hff, 8'h00);
    write_key(8'h00, 8'hff);
  endtask

  task automatic test_known_key();
    logic [7:0] plain [9];
    int k;
    plain = '{8'h50, 8'h6c, 8'h61, 8'h69, 8'h6e, 8'h74, 8'h65, 8'h78, 8'h74};
    write_key(8'd0, 8'h4b);
    write_key(8'd1, 8'h65);
    write_key(8'd2, 8'h79);
    schedule_key(9'd3);
    for (k = 0; k < 9; k++) crypt_byte(plain[k], k == 8);
    // zero length runs as one byte of key
    schedule_key(9'd0);
    crypt_byte(8'h00, 1'b1);
    schedule_key(9'd2);
    crypt_byte(8'hff, 1'b0);
  endtask

  task automatic test_full_key();
    int k;
    load_key(KEY_DEPTH_DEF);
    schedule_key(9'd256);
    for (k = 0; k < 16; k++) crypt_byte(8'($urandom), k == 15);
    // lengths above the store depth clamp to it
    schedule_key(9'h1ff);
    for (k = 0; k < 8; k++) crypt_byte(8'($urandom), 1'($urandom));
    schedule_key(9'($urandom_range(257, 510)));
    for (k = 0; k < 8; k++) crypt_byte(8'($urandom), 1'($urandom));
  endtask

  task automatic test_back_to_back();
    int k;
    no_idle = 1'b1;
    schedule_key(9'($urandom_range(1, key_prefix())));
    for (k = 0; k < 150; k++) crypt_byte(8'($urandom), $urandom_range(0, 9) == 0);
    no_idle = 1'b0;
  endtask

  task automatic test_random_sessions(input int target);
    int key_len, run_len, pick, prefix, k;
    logic [8:0] len_sel;
    while (words_sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) key_len = $urandom_range(1, 8);
      else if (pick < 95) key_len = $urandom_range(9, 32);
      else key_len = $urandom_range(33, 96);
      load_key(key_len);
      if ($urandom_range(0, 5) == 0) send_unused();
      prefix = key_prefix();
      pick = $urandom_range(0, 99);
      if (pick < 55) len_sel = 9'(key_len);
      else if (pick < 75) len_sel = 9'($urandom_range(1, prefix));
      else if (pick < 85) len_sel = 9'd0;
      else if (pick < 95 && prefix == KEY_DEPTH_DEF) len_sel = 9'($urandom_range(256, 511));
      else len_sel = 9'(key_len);
      // now and then the schedule is left out and data runs on the old s-box
      if ($urandom_range(0, 9) != 0) schedule_key(len_sel);
      run_len = $urandom_range(1, 40);
      for (k = 0; k < run_len; k++) begin
        if ($urandom_range(0, 19) == 0) send_unused();
        crypt_byte(8'($urandom), (k == run_len - 1) || ($urandom_range(0, 7) == 0));
      end
    end
  endtask

  always @(posedge clk_i) begin : result_check
    cipher_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result word: out_byte %h end_of_block %b keyed %b",
               m_axis_tdata_o, m_axis_tlast_o, m_axis_tuser_o);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (m_axis_tdata_o !== want.out_byte) begin
          $error("out_byte: expected %h, actual %h", want.out_byte, m_axis_tdata_o);
          error_count++;
        end
        if (m_axis_tlast_o !== want.end_of_block) begin
          $error("end_of_block: expected %b, actual %b", want.end_of_block, m_axis_tlast_o);
          error_count++;
        end
        if (m_axis_tuser_o !== want.keyed) begin
          $error("keyed: expected %b, actual %b", want.keyed, m_axis_tuser_o);
          error_count++;
        end
      end
    end
    m_axis_tready_i <= no_idle || ($urandom_range(0, 99) >= IDLE_PERCENT);
  end

  initial begin
    int k;
    for (k = 0; k < SBOX_DEPTH; k++) sbox_shadow[k] = 8'(k);
    for (k = 0; k < KEY_DEPTH_DEF; k++) begin
      key_shadow[k]  = '0;
      key_written[k] = 1'b0;
    end
    ptr_i = '0;
    ptr_j = '0;
    keyed_shadow = 1'b0;
    words_sent = 0;
    no_idle = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_before_keying();
    test_known_key();
    drain_results();
    test_random_sessions(FIRST_WORDS);
    drain_results();
    test_back_to_back();
    test_full_key();
    test_random_sessions(TOTAL_WORDS);

    drain_results();
    repeat (16) @(posedge clk_i);
    if (error_count == 0) begin
      $display("tb_rc4_stream_cipher_unit: done, clean");
    end else begin
      $display("tb_rc4_stream_cipher_unit: done, errors");
    end
    $finish;
  end

endmodule
